// ===== design/fsba_pkg.sv =====
// Shared types and constants for the fit strategy block allocator.
package fsba_pkg;

	localparam int NUM_BLOCKS = 16;
	localparam int IDX_W      = $clog2(NUM_BLOCKS);
	localparam int CNT_W      = $clog2(NUM_BLOCKS + 1);
	localparam int CFG_CNT_W  = 5;
	localparam int CMP_W      = (CNT_W > CFG_CNT_W) ? CNT_W : CFG_CNT_W;
	localparam int SIZE_W     = 16;
	localparam int PADDR_W    = 3;
	localparam int PDATA_W    = 32;

	typedef enum logic [1:0] {
		ACT_LOAD    = 2'd0,
		ACT_ALLOC   = 2'd1,
		ACT_RELEASE = 2'd2,
		ACT_UNUSED  = 2'd3
	} fsba_action_t;

	typedef enum logic [1:0] {
		STRAT_FIRST = 2'd0,
		STRAT_NEXT  = 2'd1,
		STRAT_WORST = 2'd2,
		STRAT_NONE  = 2'd3
	} fsba_strategy_t;

	typedef enum logic {
		REG_STRATEGY = 1'b0,
		REG_BLOCKS   = 1'b1
	} fsba_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_FINISH
	} fsba_state_t;

	typedef struct packed {
		logic [1:0]        action;
		logic [3:0]        slot;
		logic [SIZE_W-1:0] amount;
	} fsba_req_t;

	typedef struct packed {
		logic              granted;
		logic [3:0]        block_index;
		logic [SIZE_W-1:0] leftover;
	} fsba_res_t;

endpackage

// ===== design/fit_strategy_block_allocator.sv =====
// Top level of the fit strategy block allocator: size table, marks, scan engine.
//
// A fixed partition allocator. Software loads a table of block sizes, one entry
// per transfer, and then issues allocate requests that are each granted one free
// block at least as large as the request, picked by first fit, next fit or worst
// fit. A release transfer frees every block at once.
//
// Channels: an input transfer is taken at a clock edge where start is high and
// busy is low; the request struct carries action, slot and amount. Every input
// transfer yields exactly one result transfer, shown on result for one cycle with
// done high; the receiver cannot stall it. The APB port sets the strategy (byte
// address 0) and the number of participating blocks (byte address 4); the user
// must write it only while busy is low; the block does not enforce this.
//
// Timing: load, release, refused and unused actions give done in the cycle after
// the input transfer. An allocate walks the size memory one entry per cycle
// through its single read port, covering count entries, count being the active
// block count (16 at reset); a drain state follows before done. The next input
// transfer can be taken in the cycle after done.
//
// Reset clears the in-use marks, the next-fit pointer and both registers
// (strategy first fit, all 16 blocks active). The size table is not cleared; it
// must be loaded before allocation.
module fit_strategy_block_allocator
	import fsba_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [PADDR_W-1:0]  paddr,
	input  logic [PDATA_W-1:0]  pwdata,
	output logic [PDATA_W-1:0]  prdata,
	output logic                pready,
	input  logic                start,
	output logic                busy,
	input  fsba_req_t           request,
	output logic                done,
	output fsba_res_t           result
);

	// Configuration registers.
	logic [1:0]           strategy_q;
	logic [CFG_CNT_W-1:0] blocks_q;

	// Control state.
	fsba_state_t          state_q, state_d;
	logic [NUM_BLOCKS-1:0] taken_q;
	logic [IDX_W-1:0]     next_start_q;
	logic [IDX_W-1:0]     rd_idx_q;
	logic [CNT_W-1:0]     remaining_q;
	logic                 found_q;
	logic                 rd_vld_s1;

	// Payload registers.
	fsba_req_t            req_q;
	logic [IDX_W-1:0]     pick_q;
	logic [SIZE_W-1:0]    rest_q;
	logic [IDX_W-1:0]     rd_idx_s1;
	logic [SIZE_W-1:0]    rd_data_s1;

	// Size table: one write port for loads, one registered read port for the scan.
	logic [SIZE_W-1:0]    size_mem [NUM_BLOCKS];

	logic                 accept;
	logic                 mem_we;
	logic                 clear_all;
	logic                 scan_go;
	logic                 cfg_we;
	logic [CNT_W-1:0]     count;
	logic [IDX_W-1:0]     start_idx;
	logic [IDX_W-1:0]     rd_idx_next;
	logic                 fits;
	logic [SIZE_W-1:0]    rest;

	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && pready;

	always_comb begin
		unique case (fsba_reg_t'(paddr[2])) 
			REG_STRATEGY: prdata = {{(PDATA_W-2){1'b0}}, strategy_q};
			REG_BLOCKS:   prdata = {{(PDATA_W-CFG_CNT_W){1'b0}}, blocks_q};
		endcase
	end

	// Active count saturates at the table depth.
	always_comb begin
		if (CMP_W'(blocks_q) > CMP_W'(NUM_BLOCKS)) begin
			count = CNT_W'(NUM_BLOCKS);
		end else begin
			count = CNT_W'(blocks_q);
		end
	end

	// Next fit resumes at the last granted block unless that pointer fell
	// outside the active range; the other strategies start at block zero.
	always_comb begin
		if (strategy_q == STRAT_NEXT && CNT_W'(next_start_q) < count) begin
			start_idx = next_start_q;
		end else begin
			start_idx = '0;
		end
	end

	always_comb begin
		if (CNT_W'(rd_idx_q) + CNT_W'(1) == count) begin
			rd_idx_next = '0;
		end else begin
			rd_idx_next = rd_idx_q + IDX_W'(1);
		end
	end

	// Evaluation of the entry whose size just came out of the memory.
	assign fits = !taken_q[rd_idx_s1] && (rd_data_s1 >= req_q.amount);
	assign rest = rd_data_s1 - req_q.amount;

	assign accept = start && !busy;
	assign busy   = (state_q != ST_IDLE);
	assign done   = (state_q == ST_FINISH);

	always_comb begin
		state_d   = state_q;
		mem_we    = 1'b0;
		clear_all = 1'b0;
		scan_go   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_FINISH;
					unique case (request.action)
						ACT_LOAD: begin
							mem_we = (32'(request.slot) < NUM_BLOCKS);
						end
						ACT_RELEASE: begin
							clear_all = 1'b1;
						end
						ACT_ALLOC: begin
							if (count != '0 && strategy_q != STRAT_NONE) begin
								scan_go = 1'b1;
								state_d = ST_SCAN;
							end
						end
						default: begin
							state_d = ST_FINISH;
						end
					endcase
				end
			end
			ST_SCAN: begin
				if (remaining_q == CNT_W'(1)) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strategy_q <= STRAT_FIRST;
			blocks_q   <= CFG_CNT_W'(16);
		end else if (cfg_we) begin
			unique case (fsba_reg_t'(paddr[2]))
				REG_STRATEGY: strategy_q <= pwdata[1:0];
				REG_BLOCKS:   blocks_q   <= pwdata[CFG_CNT_W-1:0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			taken_q      <= '0;
			next_start_q <= '0;
			rd_idx_q     <= '0;
			remaining_q  <= '0;
			found_q      <= 1'b0;
			rd_vld_s1    <= 1'b0;
		end else begin
			rd_vld_s1 <= (state_q == ST_SCAN);
			if (accept) begin
				found_q <= 1'b0;
			end
			if (scan_go) begin
				rd_idx_q    <= start_idx;
				remaining_q <= count;
			end
			if (state_q == ST_SCAN) begin
				rd_idx_q    <= rd_idx_next;
				remaining_q <= remaining_q - CNT_W'(1);
			end
			// First and next fit keep the first hit in scan order; worst fit
			// replaces only on a strictly larger leftover.
			if (rd_vld_s1 && fits &&
			    (!found_q || (strategy_q == STRAT_WORST && rest > rest_q))) begin
				found_q <= 1'b1;
			end
			if (clear_all) begin
				taken_q <= '0;
			end
			if (state_q == ST_FINISH && found_q) begin
				taken_q[pick_q] <= 1'b1;
				if (strategy_q == STRAT_NEXT) begin
					next_start_q <= pick_q;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= request;
		end
		rd_idx_s1 <= rd_idx_q;
		if (rd_vld_s1 && fits &&
		    (!found_q || (strategy_q == STRAT_WORST && rest > rest_q))) begin
			pick_q <= rd_idx_s1;
			rest_q <= rest;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			size_mem[IDX_W'(request.slot)] <= request.amount;
		end
		rd_data_s1 <= size_mem[rd_idx_q];
	end

	always_comb begin
		result.granted     = found_q;
		result.block_index = found_q ? 4'(pick_q) : 4'd0;
		result.leftover    = found_q ? rest_q : '0;
	end

	// A taken input transfer always makes the block busy in the next cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("input transfer taken without entering a busy state");

	// The scan never runs with an exhausted entry counter.
	a_scan_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (remaining_q != '0))
		else $error("scan running with no entries left");

	// A granted block was free when the result goes out.
	a_grant_free: assert property (@(posedge clk) disable iff (!arst_n)
		(done && found_q) |-> !taken_q[pick_q])
		else $error("granted a block that is already in use");

	// A granted block is marked in use right after the result transfer.
	a_grant_marked: assert property (@(posedge clk) disable iff (!arst_n)
		(done && found_q) |=> taken_q[$past(pick_q)])
		else $error("granted block not marked in use");

endmodule

// ===== dv/fit_strategy_block_allocator_tb.sv =====
// Self-checking testbench for the fit strategy block allocator.
`timescale 1ns / 100ps

module fit_strategy_block_allocator_tb;
	import fsba_pkg::*;

	localparam int CLK_PERIOD   = 10;
	localparam int RESET_CYCLES = 12;
	// Random stimulus size, and the point after which the sender never pauses.
	localparam int RANDOM_ITEMS = 1525;
	localparam int QUIET_FROM   = RANDOM_ITEMS - 150;
	// Slowest item is a full-table allocate, plus a little slack for done.
	localparam int TAIL_CYCLES  = NUM_BLOCKS + 4;
	// Worst case is roughly 1600 items, each with the longest pause and a full scan,
	// plus the register phases; this is several times that.
	localparam int CYCLE_LIMIT  = 400_000;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;
	logic               start;
	logic               busy;
	fsba_req_t          request;
	logic               done;
	fsba_res_t          result;

	fit_strategy_block_allocator dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.start   (start),
		.busy    (busy),
		.request (request),
		.done    (done),
		.result  (result)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Shadow copy of the allocator: size table, in-use marks, next-fit pointer
	// and the two configuration registers. It is advanced once per accepted
	// input transfer, in acceptance order, and once per register write.
	logic [SIZE_W-1:0] size_table [NUM_BLOCKS];
	bit                in_use     [NUM_BLOCKS];
	int                next_fit_ptr;
	fsba_strategy_t    cfg_strategy;
	logic [4:0]        cfg_count;

	// Outcomes still owed by the block, oldest first.
	fsba_res_t expected_outcomes [$];

	int mismatch_count;
	int cycle_count;
	int load_count;
	int alloc_count;
	int grant_count;
	int release_count;
	int phase_count;
	int results_seen;

	// One row of the directed plan. A row either rewrites both registers or
	// issues one request; a request row may carry a hand-written outcome.
	typedef struct {
		bit             set_cfg;
		fsba_strategy_t strat;
		int             count;
		fsba_req_t      req;
		bit             typed;
		fsba_res_t      want;
	} plan_row_t;

	plan_row_t directed_plan [$];

	function automatic void plan_cfg(fsba_strategy_t strat, int count);
		plan_row_t row;
		row.set_cfg = 1'b1;
		row.strat = strat;
		row.count = count;
		row.req = '0;
		row.typed = 1'b0;
		row.want = '0;
		directed_plan.push_back(row);
	endfunction

	function automatic void plan_item(fsba_action_t act, int slot, int amount, bit typed,
			bit granted, int index, int leftover);
		plan_row_t row;
		row.set_cfg = 1'b0;
		row.strat = STRAT_FIRST;
		row.count = 0;
		row.req.action = act;
		row.req.slot = 4'(slot);
		row.req.amount = SIZE_W'(amount);
		row.typed = typed;
		row.want.granted = granted;
		row.want.block_index = 4'(index);
		row.want.leftover = SIZE_W'(leftover);
		directed_plan.push_back(row);
	endfunction

	// Works out the outcome of one request and updates the shadow state the
	// way the block must.
	function automatic fsba_res_t predict_outcome(fsba_req_t req);
		fsba_res_t outcome;
		int        active;
		int        origin;
		int        idx;
		int        pick;
		int        spare;
		int        widest;
		bit        hit;
		outcome = '0;
		// Counts above the table size saturate; zero leaves nothing to scan.
		active = (int'(cfg_count) > NUM_BLOCKS) ? NUM_BLOCKS : int'(cfg_count);
		hit = 1'b0;
		pick = 0;
		widest = 0;
		case (fsba_action_t'(req.action))
			ACT_LOAD: begin
				size_table[req.slot] = req.amount;
			end
			ACT_RELEASE: begin
				// The next-fit pointer survives a release.
				foreach (in_use[i])
					in_use[i] = 1'b0;
			end
			ACT_ALLOC: begin
				case (cfg_strategy)
					STRAT_FIRST: begin
						for (int i = 0; i < active; i++) begin
							if (!hit && !in_use[i] && size_table[i] >= req.amount) begin
								hit = 1'b1;
								pick = i;
							end
						end
					end
					STRAT_NEXT: begin
						// A pointer left beyond a shrunk active set restarts at zero.
						origin = (next_fit_ptr < active) ? next_fit_ptr : 0;
						for (int i = 0; i < active; i++) begin
							idx = origin + i;
							if (idx >= active)
								idx -= active;
							if (!hit && !in_use[idx] && size_table[idx] >= req.amount) begin
								hit = 1'b1;
								pick = idx;
							end
						end
						// The pointer follows every grant, wrapped ones included.
						if (hit)
							next_fit_ptr = pick;
					end
					STRAT_WORST: begin
						// Strictly larger leftover wins, so ties keep the lowest index.
						for (int i = 0; i < active; i++) begin
							if (!in_use[i] && size_table[i] >= req.amount) begin
								spare = int'(size_table[i]) - int'(req.amount);
								if (!hit || spare > widest) begin
									hit = 1'b1;
									widest = spare;
									pick = i;
								end
							end
						end
					end
					default: begin
						// The unused strategy refuses and leaves the state alone.
					end
				endcase
				if (hit) begin
					in_use[pick] = 1'b1;
					outcome.granted = 1'b1;
					outcome.block_index = 4'(pick);
					outcome.leftover = size_table[pick] - req.amount;
				end
			end
			default: begin
				// The unused action changes nothing.
			end
		endcase
		return outcome;
	endfunction

	// Request sizes and block sizes: full range, small, the two extremes, and
	// values within two of a loaded size so exact fits and near misses happen.
	function automatic logic [SIZE_W-1:0] pick_amount();
		int near;
		case ($urandom_range(0, 4))
			0: return SIZE_W'($urandom_range(0, 65535));
			1: return SIZE_W'($urandom_range(0, 255));
			2: return $urandom_range(0, 1) ? {SIZE_W{1'b1}} : '0;
			default: begin
				near = int'(size_table[$urandom_range(0, NUM_BLOCKS - 1)])
					+ int'($urandom_range(0, 4)) - 2;
				if (near < 0)
					near = 0;
				if (near > 65535)
					near = 65535;
				return SIZE_W'(near);
			end
		endcase
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("MISMATCH at cycle %0d: %s got 0x%0h expected 0x%0h",
			cycle_count, what, got, want);
		mismatch_count++;
	endtask

	// Each result is held for a single cycle, so it is taken at the edge that
	// closes that cycle and compared field by field with the oldest outcome.
	always @(posedge clk) begin : check_results
		fsba_res_t want;
		if (arst_n && done) begin
			results_seen++;
			if (expected_outcomes.size() == 0) begin
				report_mismatch("result with no request outstanding", 32'(result), '0);
			end else begin
				want = expected_outcomes.pop_front();
				if (result.granted !== want.granted)
					report_mismatch("granted", 32'(result.granted), 32'(want.granted));
				if (result.block_index !== want.block_index)
					report_mismatch("block_index", 32'(result.block_index),
						32'(want.block_index));
				if (result.leftover !== want.leftover)
					report_mismatch("leftover", 32'(result.leftover), 32'(want.leftover));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d results outstanding",
				cycle_count, expected_outcomes.size());
			$display("Some tests failed");
			$finish;
		end
	end

	// Lets every outstanding result come back and the block go idle, so the
	// registers can be rewritten. Every request yields a result, so an empty
	// queue already means the scan is over; busy is checked for good measure.
	task automatic settle();
		start <= 1'b0;
		while (expected_outcomes.size() != 0)
			@(posedge clk);
		while (busy !== 1'b0)
			@(posedge clk);
	endtask

	// APB write of one register, then a read back of the same register.
	// Both accesses have a setup and an access cycle; pready is never low.
	// The bus is left selected; the caller releases it.
	task automatic write_register(fsba_reg_t which, logic [31:0] value);
		logic [31:0] want;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= PADDR_W'(4 * int'(which));
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		// The write lands at this edge.
		if (which == REG_STRATEGY) begin
			cfg_strategy = fsba_strategy_t'(value[1:0]);
			want = 32'(value[1:0]);
		end else begin
			cfg_count = value[4:0];
			want = 32'(value[4:0]);
		end
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== want)
			report_mismatch(which == REG_STRATEGY ? "strategy read back" :
				"blocks_in_use read back", prdata, want);
	endtask

	task automatic set_config(fsba_strategy_t strat, int count);
		settle();
		write_register(REG_STRATEGY, 32'(strat));
		write_register(REG_BLOCKS, 32'(count));
		psel    <= 1'b0;
		penable <= 1'b0;
		phase_count++;
	endtask

	// Offers one request, optionally after a short pause, and waits for the
	// transfer. At the accepting edge the shadow model is advanced and the
	// outcome queued: the hand-written one when given, else the predicted one.
	task automatic issue(fsba_req_t req, bit quiet, bit typed, fsba_res_t want);
		fsba_res_t predicted;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 11))
				@(posedge clk);
		end
		start   <= 1'b1;
		request <= req;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		predicted = predict_outcome(req);
		expected_outcomes.push_back(typed ? want : predicted);
		case (fsba_action_t'(req.action))
			ACT_LOAD:    load_count++;
			ACT_RELEASE: release_count++;
			ACT_ALLOC: begin
				alloc_count++;
				if (predicted.granted)
					grant_count++;
			end
			default: ;
		endcase
	endtask

	initial begin : stimulus
		fsba_req_t req;
		fsba_res_t no_outcome;
		fsba_strategy_t strat;
		int        count;
		int        phase_len;
		int        sent;
		int        pick;
		bit        calm;

		// Everything the block sees is known from time zero.
		arst_n  <= 1'b0;
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= '0;
		pwdata  <= '0;
		start   <= 1'b0;
		request <= '0;
		no_outcome = '0;

		// Shadow state after reset. Sizes start at zero but are never relied
		// on before being loaded: no scan ever covers an unloaded entry.
		foreach (size_table[i]) begin
			size_table[i] = '0;
			in_use[i] = 1'b0;
		end
		next_fit_ptr = 0;
		cfg_strategy = STRAT_FIRST;
		cfg_count = 5'd16;

		repeat (RESET_CYCLES)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed plan. The active set is kept to entries that have been
		// loaded, since the table itself is not cleared by reset.
		plan_cfg(STRAT_FIRST, 0);
		// With no active blocks every request is refused.
		plan_item(ACT_ALLOC, 0, 0, 1, 0, 0, 0);
		plan_item(ACT_RELEASE, 0, 0, 1, 0, 0, 0);
		plan_item(ACT_UNUSED, 15, 65535, 1, 0, 0, 0);
		plan_cfg(STRAT_FIRST, 3);
		plan_item(ACT_LOAD, 0, 65535, 1, 0, 0, 0);
		plan_item(ACT_LOAD, 1, 0, 1, 0, 0, 0);
		plan_item(ACT_LOAD, 2, 100, 1, 0, 0, 0);
		plan_item(ACT_LOAD, 15, 16'h5A5A, 1, 0, 0, 0);
		plan_item(ACT_ALLOC, 0, 0, 1, 1, 0, 65535);
		plan_item(ACT_ALLOC, 0, 0, 1, 1, 1, 0);
		// Only the 100-sized block is free, so the largest request is refused.
		plan_item(ACT_ALLOC, 0, 65535, 1, 0, 0, 0);
		plan_item(ACT_ALLOC, 0, 100, 0, 0, 0, 0);
		plan_item(ACT_RELEASE, 0, 0, 1, 0, 0, 0);
		// The unused strategy refuses even a zero-sized request.
		plan_cfg(STRAT_NONE, 3);
		plan_item(ACT_ALLOC, 0, 0, 1, 0, 0, 0);
		// Next fit: a plain grant, a forward scan, then a grant that wraps.
		plan_cfg(STRAT_NEXT, 3);
		plan_item(ACT_ALLOC, 0, 0, 0, 0, 0, 0);
		plan_item(ACT_ALLOC, 0, 50, 0, 0, 0, 0);
		plan_item(ACT_ALLOC, 0, 0, 0, 0, 0, 0);
		plan_item(ACT_RELEASE, 0, 0, 1, 0, 0, 0);
		plan_item(ACT_ALLOC, 0, 60, 0, 0, 0, 0);
		// The pointer now sits past a shrunk active set and must restart at zero.
		plan_cfg(STRAT_NEXT, 2);
		plan_item(ACT_ALLOC, 0, 0, 0, 0, 0, 0);
		// Worst fit with two equal leftovers to show the lowest index winning.
		plan_cfg(STRAT_WORST, 3);
		plan_item(ACT_RELEASE, 0, 0, 1, 0, 0, 0);
		plan_item(ACT_LOAD, 1, 100, 1, 0, 0, 0);
		plan_item(ACT_ALLOC, 0, 10, 0, 0, 0, 0);
		plan_item(ACT_ALLOC, 0, 10, 0, 0, 0, 0);
		plan_item(ACT_ALLOC, 0, 10, 0, 0, 0, 0);

		foreach (directed_plan[i]) begin
			if (directed_plan[i].set_cfg)
				set_config(directed_plan[i].strat, directed_plan[i].count);
			else
				issue(directed_plan[i].req, 1'b0, directed_plan[i].typed,
					directed_plan[i].want);
		end

		// Load the whole table once so any active count is legal from here on.
		set_config(STRAT_FIRST, NUM_BLOCKS);
		sent = 0;
		for (int s = 0; s < NUM_BLOCKS; s++) begin
			req.action = ACT_LOAD;
			req.slot = 4'(s);
			req.amount = pick_amount();
			issue(req, 1'b0, 1'b0, no_outcome);
			sent++;
		end

		// Random phases: each one picks a strategy and an active count, then
		// runs a mix weighted toward allocation, with reloads to reshape the
		// table and occasional releases so full tables and refusals occur.
		while (sent < RANDOM_ITEMS) begin
			pick = $urandom_range(0, 9);
			strat = (pick < 3) ? STRAT_FIRST : (pick < 6) ? STRAT_NEXT :
				(pick < 9) ? STRAT_WORST : STRAT_NONE;
			case ($urandom_range(0, 9))
				0: count = 0;
				1: count = 1;
				2: count = NUM_BLOCKS;
				3: count = 31;
				4: count = $urandom_range(NUM_BLOCKS + 1, 30);
				default: count = $urandom_range(2, NUM_BLOCKS - 1);
			endcase
			set_config(strat, count);
			// Some phases run back to back with no pauses at all.
			calm = ($urandom_range(0, 3) == 0);
			phase_len = $urandom_range(40, 120);
			for (int n = 0; n < phase_len && sent < RANDOM_ITEMS; n++) begin
				pick = $urandom_range(0, 99);
				req.slot = 4'($urandom_range(0, NUM_BLOCKS - 1));
				req.amount = pick_amount();
				if (pick < 62)
					req.action = ACT_ALLOC;
				else if (pick < 84)
					req.action = ACT_LOAD;
				else if (pick < 95)
					req.action = ACT_RELEASE;
				else
					req.action = ACT_UNUSED;
				issue(req, calm || sent >= QUIET_FROM, 1'b0, no_outcome);
				// Ignored actions do not count toward the stimulus size.
				if (req.action != ACT_UNUSED)
					sent++;
			end
		end

		start <= 1'b0;
		while (expected_outcomes.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES)
			@(posedge clk);

		$display("Run covered %0d results over %0d register phases: %0d loads, %0d releases,",
			results_seen, phase_count, load_count, release_count);
		$display("and %0d allocate requests of which %0d were granted.",
			alloc_count, grant_count);
		if (mismatch_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
